// ===== hw/rtl/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int CAP_W            = 4;
   localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

   localparam int MAX_ENTRIES_DEF  = 8;
   localparam int KEY_BITS_DEF     = 31;
   localparam int VALUE_BITS_DEF   = 31;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // Per-transaction control broadcast to every cell of the chain
   typedef struct packed {
      logic accept;  // transaction taken this cycle
      logic put;     // put rather than get
      logic hit;     // key found somewhere in the chain
      logic full;    // fill has reached the capacity in use
   } cell_cmd_type;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel (req_valid / req_stall): req_action selects get or put,
// req_key is the key, req_write_value the value stored by a put. A request
// is taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall): one response per request, in
// order. rsp_hit reports whether the key was present; rsp_read_value holds
// the stored value on a get hit and zero otherwise.
// The response is registered, and one request per cycle is sustained while
// the response is not stalled: every cell of the recency chain compares its
// key, and the shifting cells move their entries to their neighbors together.
// When the receiver stalls, the response is held and req_stall rises only
// while the held response is still stalled.
// csr_write_enable / csr_write_data set the capacity in use (0 acts as 1,
// values above the entry count act as the entry count); write it only while
// no request is in flight. Reset empties the cache at once and sets the
// capacity to 8.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_action,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [VALUE_BITS-1:0]      req_write_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_hit,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   input  logic                       csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data
);
   import lkvc_pkg::*;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_read_value_ff, rsp_read_value_in;

   logic                  accept;
   logic                  is_put;
   logic                  full;
   logic                  head_hit;
   logic [VALUE_BITS-1:0] head_data;
   logic [VALUE_BITS-1:0] new_data;
   cell_cmd_type          cmd;

   logic [MAX_ENTRIES:0]                 hit_chain;
   logic [MAX_ENTRIES:0][VALUE_BITS-1:0] data_chain;
   logic [MAX_ENTRIES-1:0]               cell_valid;
   logic [MAX_ENTRIES-1:0][KEY_BITS-1:0] cell_key;
   logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] cell_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_put    = (req_action == ACTION_PUT);

   assign hit_chain[MAX_ENTRIES]  = 1'b0;
   assign data_chain[MAX_ENTRIES] = '0;
   assign head_hit  = hit_chain[0];
   assign head_data = data_chain[0];

   // Filled cells form a prefix, so the fill reaches the capacity when the
   // cell at that depth holds an entry; the last cell covers oversized values.
   always_comb begin
      full = 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cell_valid[i] && ((32'(cap_ff) <= 32'(i + 1)) || (i == MAX_ENTRIES - 1))) begin
            full = 1'b1;
         end
      end
   end

   assign new_data = is_put ? req_write_value : head_data;

   always_comb begin
      cmd.accept = accept;
      cmd.put    = is_put;
      cmd.hit    = head_hit;
      cmd.full   = full;
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic                  up_valid;
      logic [KEY_BITS-1:0]   up_key;
      logic [VALUE_BITS-1:0] up_data;

      if (g == 0) begin : g_head
         assign up_valid = 1'b1;
         assign up_key   = req_key;
         assign up_data  = new_data;
      end else begin : g_body
         assign up_valid = cell_valid[g-1];
         assign up_key   = cell_key[g-1];
         assign up_data  = cell_data[g-1];
      end

      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .req_key    (req_key),
         .up_valid   (up_valid),
         .up_key     (up_key),
         .up_data    (up_data),
         .hit_below  (hit_chain[g+1]),
         .data_below (data_chain[g+1]),
         .hit_out    (hit_chain[g]),
         .data_out   (data_chain[g]),
         .valid      (cell_valid[g]),
         .key        (cell_key[g]),
         .data       (cell_data[g])
      );
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_read_value_in = rsp_read_value_ff;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_hit_in        = head_hit;
         rsp_read_value_in = (head_hit && !is_put) ? head_data : '0;
      end else if (!rsp_stall) begin
         // drop the response once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff        <= rsp_hit_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

// ===== hw/rtl/lkvc_cell.sv =====
module lkvc_cell #(
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::cell_cmd_type cmd,
   input  logic [KEY_BITS-1:0]    req_key,
   // entry arriving from the more recent neighbor
   input  logic                   up_valid,
   input  logic [KEY_BITS-1:0]    up_key,
   input  logic [VALUE_BITS-1:0]  up_data,
   // match summary from the less recent neighbors
   input  logic                   hit_below,
   input  logic [VALUE_BITS-1:0]  data_below,
   // match summary including this cell
   output logic                   hit_out,
   output logic [VALUE_BITS-1:0]  data_out,
   // stored entry
   output logic                   valid,
   output logic [KEY_BITS-1:0]    key,
   output logic [VALUE_BITS-1:0]  data
);
   import lkvc_pkg::*;

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] data_ff, data_in;
   logic                  match;
   logic                  shift;

   assign match    = valid_ff && (key_ff == req_key);
   assign hit_out  = match | hit_below;
   assign data_out = (match ? data_ff : '0) | data_below;

   // Cells from the head down to the hit, or over the whole filled prefix
   // (plus the first empty cell when not full) on an insert, move down by one.
   always_comb begin
      if (cmd.hit) begin
         shift = hit_out;
      end else if (cmd.put) begin
         shift = cmd.full ? valid_ff : up_valid;
      end else begin
         shift = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (cmd.accept && shift) begin
         valid_in = up_valid;
         key_in   = up_key;
         data_in  = up_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign data  = data_ff;

endmodule
